### src/rbe_pkg.sv
// Shared constants, types and command/status structs of the run-length block encoder.
`default_nettype none

package rbe_pkg;

    // Longest run and longest literal block, in bytes.
    localparam int MAX_BLOCK = 32;
    localparam int LEN_W     = $clog2(MAX_BLOCK + 1);
    localparam int ADDR_W    = $clog2(MAX_BLOCK);

    localparam logic [7:0] FLAG_RUN     = 8'd1;
    localparam logic [7:0] FLAG_LITERAL = 8'd0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_RUN_FLAG,
        S_RUN_SYM,
        S_RUN_LEN,
        S_LIT_FLAG,
        S_LIT_LEN,
        S_LIT_DATA
    } t_state;

    typedef enum logic [2:0] {
        SEL_RUN_FLAG,
        SEL_LIT_FLAG,
        SEL_RUN_SYM,
        SEL_RUN_LEN,
        SEL_LIT_LEN,
        SEL_LIT_DATA
    } t_emit_sel;

    typedef struct packed {
        logic      load;
        logic      pop;
        logic      extend_run;
        logic      start_run;
        logic      store_lit;
        logic      clear_run;
        logic      clear_lit;
        logic      clear_last;
        logic      rd_en;
        logic      rd_first;
        logic      emit;
        logic      emit_final;
        t_emit_sel emit_sel;
    } t_cmd;

    typedef struct packed {
        logic [1:0] qn;
        logic       last;
        logic       run_open;
        logic       run_full;
        logic       lit_empty;
        logic       lit_full;
        logic       head_eq_sym;
        logic       triple;
        logic       lit_last;
        logic       out_free;
    } t_status;

endpackage

`default_nettype wire

### src/rle_block_encoder.sv
// Top level of the byte run-length encoder with literal blocks.
//
// Bytes enter on the slave stream, tlast marking the final byte of a stream, and the
// encoded bytes leave on the master stream: runs of three or more equal bytes as
// 1, symbol, count, other bytes as literal blocks 0, length, bytes, both capped at
// MAX_BLOCK, with tlast on the last encoded byte of each stream. The controller makes
// one encoding decision per cycle on a three-byte lookahead queue while no block is
// being sent, and the output register sends one encoded byte per cycle while the
// master side holds tready high. A byte is accepted, then decided on. A run or a
// literal block is closed by a decision, then its code bytes are sent; a stream end
// also clears its end mark. The input side is not ready while a run or a literal
// block is being sent.
`default_nettype none

module rle_block_encoder (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_tvalid,
    output logic            o_s_tready,
    input  wire logic [7:0] i_s_tdata,   // data_byte
    input  wire logic       i_s_tlast,   // end_of_stream
    output logic            o_m_tvalid,
    input  wire logic       i_m_tready,
    output logic [7:0]      o_m_tdata,   // code_byte
    output logic            o_m_tlast    // final_byte
);

    rbe_pkg::t_cmd    cmd;
    rbe_pkg::t_status status;

    rbe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_status   (status),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .o_cmd      (cmd)
    );

    rbe_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_in_byte  (i_s_tdata),
        .i_in_last  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    // The lookahead queue never overflows.
    a_queue_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> status.qn != 2'd3)
        else $error("beat accepted with a full lookahead queue");

    // A run and a literal block are never open together.
    a_run_lit_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(status.run_open && !status.lit_empty))
        else $error("run and literal block open at once");

    // An end-of-stream mark on the output only follows a last input beat.
    a_final_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.emit && cmd.emit_final) |-> status.last)
        else $error("final byte emitted outside a last beat");

    // Every emitted beat lands in a free output register.
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> status.out_free)
        else $error("beat emitted over a held output");

endmodule

`default_nettype wire

### src/rbe_datapath.sv
// Datapath: lookahead queue, run and literal registers, literal memory and output register.
`default_nettype none

module rbe_datapath (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire rbe_pkg::t_cmd  i_cmd,
    output rbe_pkg::t_status    o_status,
    input  wire logic [7:0]     i_in_byte,
    input  wire logic           i_in_last,
    output logic                o_m_tvalid,
    input  wire logic           i_m_tready,
    output logic [7:0]          o_m_tdata,   // code_byte
    output logic                o_m_tlast
);

    logic [7:0]                 r_q [3];
    logic [1:0]                 r_qn;
    logic                       r_last;
    logic [7:0]                 r_run_sym;
    logic [rbe_pkg::LEN_W-1:0]  r_run_len;
    logic [rbe_pkg::LEN_W-1:0]  r_lit_cnt;
    logic [rbe_pkg::ADDR_W-1:0] r_rd_idx;
    logic [7:0]                 r_rd_data;
    logic [7:0]                 mem [rbe_pkg::MAX_BLOCK];
    logic [rbe_pkg::ADDR_W-1:0] rd_addr;
    logic [rbe_pkg::LEN_W-1:0]  idx_plus1;
    logic [7:0]                 emit_byte;

    assign idx_plus1 = rbe_pkg::LEN_W'(r_rd_idx) + rbe_pkg::LEN_W'(1);
    assign rd_addr   = i_cmd.rd_first ? '0 : idx_plus1[rbe_pkg::ADDR_W-1:0];

    always_comb begin
        o_status.qn          = r_qn;
        o_status.last        = r_last;
        o_status.run_open    = (r_run_len != '0);
        o_status.run_full    = (r_run_len == rbe_pkg::LEN_W'(rbe_pkg::MAX_BLOCK));
        o_status.lit_empty   = (r_lit_cnt == '0);
        o_status.lit_full    = (r_lit_cnt == rbe_pkg::LEN_W'(rbe_pkg::MAX_BLOCK));
        o_status.head_eq_sym = (r_q[0] == r_run_sym);
        o_status.triple      = (r_qn == 2'd3) && (r_q[0] == r_q[1]) && (r_q[0] == r_q[2]);
        o_status.lit_last    = (idx_plus1 == r_lit_cnt);
        o_status.out_free    = !o_m_tvalid || i_m_tready;
    end

    always_comb begin
        case (i_cmd.emit_sel)
            rbe_pkg::SEL_RUN_FLAG: emit_byte = rbe_pkg::FLAG_RUN;
            rbe_pkg::SEL_LIT_FLAG: emit_byte = rbe_pkg::FLAG_LITERAL;
            rbe_pkg::SEL_RUN_SYM:  emit_byte = r_run_sym;
            rbe_pkg::SEL_RUN_LEN:  emit_byte = 8'(r_run_len);
            rbe_pkg::SEL_LIT_LEN:  emit_byte = 8'(r_lit_cnt);
            rbe_pkg::SEL_LIT_DATA: emit_byte = r_rd_data;
            default:               emit_byte = r_rd_data;
        endcase
    end

    // Queue payload: new bytes enter at the tail, decisions consume the head.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_q[r_qn] <= i_in_byte;
        end else if (i_cmd.pop) begin
            r_q[0] <= r_q[1];
            r_q[1] <= r_q[2];
        end
        if (i_cmd.start_run) begin
            r_run_sym <= r_q[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qn      <= '0;
            r_last    <= 1'b0;
            r_run_len <= '0;
            r_lit_cnt <= '0;
        end else begin
            if (i_cmd.load) begin
                r_qn   <= r_qn + 2'd1;
                r_last <= i_in_last;
            end else begin
                if (i_cmd.pop) begin
                    r_qn <= r_qn - 2'd1;
                end
                if (i_cmd.clear_last) begin
                    r_last <= 1'b0;
                end
            end
            if (i_cmd.start_run) begin
                r_run_len <= rbe_pkg::LEN_W'(1);
            end else if (i_cmd.extend_run) begin
                r_run_len <= r_run_len + rbe_pkg::LEN_W'(1);
            end else if (i_cmd.clear_run) begin
                r_run_len <= '0;
            end
            if (i_cmd.store_lit) begin
                r_lit_cnt <= r_lit_cnt + rbe_pkg::LEN_W'(1);
            end else if (i_cmd.clear_lit) begin
                r_lit_cnt <= '0;
            end
        end
    end

    // Literal memory: written at the fill level, read one byte ahead of emission.
    always_ff @(posedge i_clk) begin
        if (i_cmd.store_lit) begin
            mem[r_lit_cnt[rbe_pkg::ADDR_W-1:0]] <= r_q[0];
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= mem[rd_addr];
            r_rd_idx  <= rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_m_tvalid <= 1'b0;
        end else if (i_cmd.emit) begin
            o_m_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            o_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_m_tdata <= emit_byte;
            o_m_tlast <= i_cmd.emit_final;
        end
    end

endmodule

`default_nettype wire

### src/rbe_ctrl.sv
// Controller: one encoding decision per cycle between blocks, then run and literal block output.
`default_nettype none

module rbe_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire rbe_pkg::t_status i_status,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    output rbe_pkg::t_cmd         o_cmd
);

    rbe_pkg::t_state r_state;
    rbe_pkg::t_state n_state;
    logic            r_close_final;
    logic            n_close_final;
    logic            close_is_final;

    // A close ends the stream when the last beat is in and the queue is drained.
    assign close_is_final = i_status.last && (i_status.qn == 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= rbe_pkg::S_IDLE;
            r_close_final <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_close_final <= n_close_final;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_close_final = r_close_final;
        o_in_ready    = 1'b0;
        o_cmd         = '0;
        o_cmd.emit_sel = rbe_pkg::SEL_RUN_FLAG;
        case (r_state)
            rbe_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = rbe_pkg::S_DECIDE;
                end
            end
            rbe_pkg::S_DECIDE: begin
                if (i_status.run_full) begin
                    n_close_final = close_is_final;
                    n_state       = rbe_pkg::S_RUN_FLAG;
                end else if (i_status.lit_full) begin
                    n_close_final = close_is_final;
                    n_state       = rbe_pkg::S_LIT_FLAG;
                end else if (i_status.qn == 2'd0 && i_status.last) begin
                    n_close_final = 1'b1;
                    if (i_status.run_open) begin
                        n_state = rbe_pkg::S_RUN_FLAG;
                    end else if (!i_status.lit_empty) begin
                        n_state = rbe_pkg::S_LIT_FLAG;
                    end else begin
                        o_cmd.clear_last = 1'b1;
                        n_state          = rbe_pkg::S_IDLE;
                    end
                end else if (i_status.run_open && i_status.qn != 2'd0) begin
                    if (i_status.head_eq_sym) begin
                        o_cmd.extend_run = 1'b1;
                        o_cmd.pop        = 1'b1;
                    end else begin
                        n_close_final = 1'b0;
                        n_state       = rbe_pkg::S_RUN_FLAG;
                    end
                end else if (i_status.qn != 2'd3 && !i_status.last) begin
                    // Not enough lookahead: take the next beat right away.
                    o_in_ready = 1'b1;
                    if (i_in_valid) begin
                        o_cmd.load = 1'b1;
                    end else begin
                        n_state = rbe_pkg::S_IDLE;
                    end
                end else if (i_status.lit_empty) begin
                    o_cmd.pop = 1'b1;
                    if (i_status.triple) begin
                        o_cmd.start_run = 1'b1;
                    end else begin
                        o_cmd.store_lit = 1'b1;
                    end
                end else if (i_status.triple) begin
                    n_close_final = 1'b0;
                    n_state       = rbe_pkg::S_LIT_FLAG;
                end else begin
                    o_cmd.store_lit = 1'b1;
                    o_cmd.pop       = 1'b1;
                end
            end
            rbe_pkg::S_RUN_FLAG: begin
                o_cmd.emit_sel = rbe_pkg::SEL_RUN_FLAG;
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = rbe_pkg::S_RUN_SYM;
                end
            end
            rbe_pkg::S_RUN_SYM: begin
                o_cmd.emit_sel = rbe_pkg::SEL_RUN_SYM;
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = rbe_pkg::S_RUN_LEN;
                end
            end
            rbe_pkg::S_RUN_LEN: begin
                o_cmd.emit_sel   = rbe_pkg::SEL_RUN_LEN;
                o_cmd.emit_final = r_close_final;
                if (i_status.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.clear_run = 1'b1;
                    n_state         = rbe_pkg::S_DECIDE;
                end
            end
            rbe_pkg::S_LIT_FLAG: begin
                o_cmd.emit_sel = rbe_pkg::SEL_LIT_FLAG;
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = rbe_pkg::S_LIT_LEN;
                end
            end
            rbe_pkg::S_LIT_LEN: begin
                o_cmd.emit_sel = rbe_pkg::SEL_LIT_LEN;
                if (i_status.out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.rd_en    = 1'b1;
                    o_cmd.rd_first = 1'b1;
                    n_state        = rbe_pkg::S_LIT_DATA;
                end
            end
            rbe_pkg::S_LIT_DATA: begin
                o_cmd.emit_sel   = rbe_pkg::SEL_LIT_DATA;
                o_cmd.emit_final = r_close_final && i_status.lit_last;
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.lit_last) begin
                        o_cmd.clear_lit = 1'b1;
                        n_state         = rbe_pkg::S_DECIDE;
                    end else begin
                        o_cmd.rd_en = 1'b1;
                    end
                end
            end
            default: begin
                n_state = rbe_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire
